// ----- rtl/core/vfa_pkg.sv -----
// ----------------------------------------------------------------------------
// vfa_pkg
// Shared types and constants for the Q16.16 three-component vector ALU.
// ----------------------------------------------------------------------------
package vfa_pkg;

    localparam int Q_W    = 32;   // Q16.16 word
    localparam int FRAC_W = 16;   // fraction bits
    localparam int CMD_W  = 4;
    localparam int SQ_W   = 64;   // sum of squares
    localparam int ROOT_W = 32;   // integer square root of SQ_W bits
    localparam int DVD_W  = 48;   // dividend: magnitude shifted up by FRAC_W
    localparam int DVS_W  = 32;   // divisor: norm or scalar magnitude

    localparam logic [Q_W-1:0] Q_MAX = 32'h7FFF_FFFF;
    localparam logic [Q_W-1:0] Q_MIN = 32'h8000_0000;

    localparam logic [CMD_W-1:0] CMD_NEG   = 4'd0;
    localparam logic [CMD_W-1:0] CMD_ADD   = 4'd1;
    localparam logic [CMD_W-1:0] CMD_SUB   = 4'd2;
    localparam logic [CMD_W-1:0] CMD_SCALE = 4'd3;
    localparam logic [CMD_W-1:0] CMD_REM   = 4'd4;
    localparam logic [CMD_W-1:0] CMD_NORM  = 4'd5;
    localparam logic [CMD_W-1:0] CMD_UNIT  = 4'd6;
    localparam logic [CMD_W-1:0] CMD_DOT   = 4'd7;
    localparam logic [CMD_W-1:0] CMD_CROSS = 4'd8;

    typedef struct packed {
        logic [CMD_W-1:0]      command;
        logic signed [Q_W-1:0] a_x;
        logic signed [Q_W-1:0] a_y;
        logic signed [Q_W-1:0] a_z;
        logic signed [Q_W-1:0] b_x;
        logic signed [Q_W-1:0] b_y;
        logic signed [Q_W-1:0] b_z;
        logic signed [Q_W-1:0] scalar_in;
    } in_t;

    typedef struct packed {
        logic signed [Q_W-1:0] r_x;
        logic signed [Q_W-1:0] r_y;
        logic signed [Q_W-1:0] r_z;
        logic signed [Q_W-1:0] r_scalar;
        logic                  error_flag;
    } out_t;

endpackage

// ----- rtl/core/vec3_fixed_point_alu_top.sv -----
// ----------------------------------------------------------------------------
// vec3_fixed_point_alu_top
// Q16.16 three-component vector ALU: neg, add, sub, scale, remainder, norm,
// unit vector, and dot and cross products of unit vectors.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry one command beat (command, vectors a and b,
//   scalar). m_valid/m_ready/m_data return one result beat per command, in
//   order: r_x, r_y, r_z, r_scalar and error_flag.
//   From the accepting edge to m_valid, each beat passes through the
//   32-stage square root (one root bit per stage) followed by the 48-stage
//   divider (one quotient bit per stage) that forms remainders and unit
//   components. Every command takes the same path.
//   Throughput is one beat per cycle while m_ready is high.
//   When the receiver stalls with a result held, the whole pipeline holds
//   and s_ready drops; nothing is lost or repeated, and s_ready returns in
//   the cycle m_ready does.
//   aresetn (synchronous, active low) clears all valid bits; the block takes
//   a beat in the first cycle after reset.
// ----------------------------------------------------------------------------
module vec3_fixed_point_alu_top (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  vfa_pkg::in_t   s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output vfa_pkg::out_t  m_data
);
    import vfa_pkg::*;

    localparam int SQRT_STG = ROOT_W;
    localparam int DIV_STG  = DVD_W;

    typedef struct packed {
        logic                  vld;
        logic [CMD_W-1:0]      cmd;
        logic [2:0]            a_neg;
        logic [2:0]            b_neg;
        logic [2:0][Q_W-1:0]   a_mag;
        logic [2:0][Q_W-1:0]   b_mag;
        logic [Q_W-1:0]        s_mag;
        logic                  s_zero;
    } pre_side_t;

    typedef struct packed {
        logic                  vld;
        logic [CMD_W-1:0]      cmd;
        logic [2:0]            a_neg;
        logic [2:0]            b_neg;
        logic [2:0][Q_W-1:0]   a_mag;
        logic [2:0][Q_W-1:0]   b_mag;
        logic [Q_W-1:0]        s_mag;
        logic                  s_zero;
        logic [2:0][Q_W-1:0]   pre_r;
    } sq_side_t;

    typedef struct packed {
        logic                  vld;
        logic [CMD_W-1:0]      cmd;
        logic [2:0]            a_neg;
        logic [2:0]            b_neg;
        logic                  s_zero;
        logic                  a_zero;
        logic                  b_zero;
        logic [Q_W-1:0]        norm_s;
        logic [2:0][Q_W-1:0]   pre_r;
    } dv_side_t;

    typedef struct packed {
        logic                  vld;
        logic [CMD_W-1:0]      cmd;
        logic                  s_zero;
        logic                  a_zero;
        logic                  b_zero;
        logic [Q_W-1:0]        norm_s;
        logic [2:0][Q_W-1:0]   vec_r;
    } vr_side_t;

    function automatic logic [Q_W-1:0] sat32(input logic signed [65:0] v);
        logic [Q_W-1:0] r;
        if (v > 66'sd2147483647)
            r = Q_MAX;
        else if (v < -66'sd2147483648)
            r = Q_MIN;
        else
            r = v[Q_W-1:0];
        return r;
    endfunction

    // apply sign to an unsigned quotient and saturate
    function automatic logic [Q_W-1:0] sign_sat(input logic [DVD_W-1:0] q,
                                                input logic neg);
        logic [Q_W-1:0] r;
        if (neg) begin
            if (q > DVD_W'(Q_MIN))
                r = Q_MIN;
            else
                r = ~q[Q_W-1:0] + Q_W'(1);
        end else begin
            if (q > DVD_W'(Q_MAX))
                r = Q_MAX;
            else
                r = q[Q_W-1:0];
        end
        return r;
    endfunction

    logic en;
    assign en      = !m_valid || m_ready;
    assign s_ready = en;

    // ---------------- stage 1: input register
    in_t  in_reg;
    logic vld1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld1_reg <= 1'b0;
        end else if (en) begin
            vld1_reg <= s_valid;
        end
        if (en) begin
            in_reg <= s_data;
        end
    end

    // ---------------- stage 2: magnitudes, squares, scale products, neg/add/sub
    logic signed [Q_W-1:0] av [3];
    logic signed [Q_W-1:0] bv [3];
    logic [Q_W-1:0]        amag [3];
    logic [Q_W-1:0]        bmag [3];
    logic [Q_W-1:0]        smag;

    assign av[0] = in_reg.a_x;
    assign av[1] = in_reg.a_y;
    assign av[2] = in_reg.a_z;
    assign bv[0] = in_reg.b_x;
    assign bv[1] = in_reg.b_y;
    assign bv[2] = in_reg.b_z;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            amag[i] = av[i][Q_W-1] ? (~av[i] + Q_W'(1)) : av[i];
            bmag[i] = bv[i][Q_W-1] ? (~bv[i] + Q_W'(1)) : bv[i];
        end
        smag = in_reg.scalar_in[Q_W-1] ? (~in_reg.scalar_in + Q_W'(1)) : in_reg.scalar_in;
    end

    logic [SQ_W-1:0]        sq_a_reg [3];
    logic [SQ_W-1:0]        sq_b_reg [3];
    logic signed [2*Q_W-1:0] sp_reg  [3];
    logic [Q_W-1:0]         pre2_reg [3];
    pre_side_t              side2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side2_reg.vld <= 1'b0;
        end else if (en) begin
            side2_reg.vld <= vld1_reg;
        end
        if (en) begin
            side2_reg.cmd    <= in_reg.command;
            side2_reg.s_mag  <= smag;
            side2_reg.s_zero <= (in_reg.scalar_in == '0);
            for (int i = 0; i < 3; i++) begin
                side2_reg.a_neg[i] <= av[i][Q_W-1];
                side2_reg.b_neg[i] <= bv[i][Q_W-1];
                side2_reg.a_mag[i] <= amag[i];
                side2_reg.b_mag[i] <= bmag[i];
                sq_a_reg[i] <= SQ_W'(amag[i]) * SQ_W'(amag[i]);
                sq_b_reg[i] <= SQ_W'(bmag[i]) * SQ_W'(bmag[i]);
                sp_reg[i]   <= (2*Q_W)'(av[i]) * (2*Q_W)'(in_reg.scalar_in);
                case (in_reg.command)
                    CMD_NEG: pre2_reg[i] <= sat32(-66'(av[i]));
                    CMD_ADD: pre2_reg[i] <= sat32(66'(av[i]) + 66'(bv[i]));
                    CMD_SUB: pre2_reg[i] <= sat32(66'(av[i]) - 66'(bv[i]));
                    default: pre2_reg[i] <= '0;
                endcase
            end
        end
    end

    // ---------------- stage 3: sums of squares, scale rounding
    logic [SQ_W-1:0] rad_a_reg;
    logic [SQ_W-1:0] rad_b_reg;
    sq_side_t        sq_side_reg [SQRT_STG+1];
    logic [Q_W-1:0]  scale_r [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            scale_r[i] = sat32((66'(sp_reg[i]) + 66'sd32768) >>> FRAC_W);
        end
    end

    // side data follows the square root stages in the same block
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_side_reg[0].vld <= 1'b0;
        end else if (en) begin
            sq_side_reg[0].vld <= side2_reg.vld;
        end
        if (en) begin
            rad_a_reg <= sq_a_reg[0] + sq_a_reg[1] + sq_a_reg[2];
            rad_b_reg <= sq_b_reg[0] + sq_b_reg[1] + sq_b_reg[2];
            sq_side_reg[0].cmd    <= side2_reg.cmd;
            sq_side_reg[0].a_neg  <= side2_reg.a_neg;
            sq_side_reg[0].b_neg  <= side2_reg.b_neg;
            sq_side_reg[0].a_mag  <= side2_reg.a_mag;
            sq_side_reg[0].b_mag  <= side2_reg.b_mag;
            sq_side_reg[0].s_mag  <= side2_reg.s_mag;
            sq_side_reg[0].s_zero <= side2_reg.s_zero;
            for (int i = 0; i < 3; i++) begin
                sq_side_reg[0].pre_r[i] <= (side2_reg.cmd == CMD_SCALE) ? scale_r[i]
                                                                        : pre2_reg[i];
            end
        end
        for (int k = 1; k <= SQRT_STG; k++) begin
            if (!aresetn) begin
                sq_side_reg[k].vld <= 1'b0;
            end else if (en) begin
                sq_side_reg[k] <= sq_side_reg[k-1];
            end
        end
    end

    // ---------------- square root stages
    logic [ROOT_W-1:0] root_a;
    logic [ROOT_W-1:0] root_b;

    vfa_isqrt u_sqrt_a (.aclk(aclk), .en(en), .rad(rad_a_reg), .root(root_a));
    vfa_isqrt u_sqrt_b (.aclk(aclk), .en(en), .rad(rad_b_reg), .root(root_b));

    // ---------------- divider operand stage
    sq_side_t          sq_o;
    logic [DVD_W-1:0]  dvd_a_reg [3];
    logic [DVD_W-1:0]  dvd_b_reg [3];
    logic [DVS_W-1:0]  dvs_a_reg;
    logic [DVS_W-1:0]  dvs_b_reg;
    dv_side_t          dv_side_reg [DIV_STG+1];

    assign sq_o = sq_side_reg[SQRT_STG];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_side_reg[0].vld <= 1'b0;
        end else if (en) begin
            dv_side_reg[0].vld <= sq_o.vld;
        end
        if (en) begin
            // remainder reuses the a-side dividers
            for (int i = 0; i < 3; i++) begin
                dvd_a_reg[i] <= (sq_o.cmd == CMD_REM) ? DVD_W'(sq_o.a_mag[i])
                                                      : {sq_o.a_mag[i], FRAC_W'(0)};
                dvd_b_reg[i] <= {sq_o.b_mag[i], FRAC_W'(0)};
            end
            dvs_a_reg <= (sq_o.cmd == CMD_REM) ? sq_o.s_mag : root_a;
            dvs_b_reg <= root_b;
            dv_side_reg[0].cmd    <= sq_o.cmd;
            dv_side_reg[0].a_neg  <= sq_o.a_neg;
            dv_side_reg[0].b_neg  <= sq_o.b_neg;
            dv_side_reg[0].s_zero <= sq_o.s_zero;
            dv_side_reg[0].a_zero <= (root_a == '0);
            dv_side_reg[0].b_zero <= (root_b == '0);
            dv_side_reg[0].norm_s <= root_a[ROOT_W-1] ? Q_MAX : root_a;
            dv_side_reg[0].pre_r  <= sq_o.pre_r;
        end
        for (int k = 1; k <= DIV_STG; k++) begin
            if (!aresetn) begin
                dv_side_reg[k].vld <= 1'b0;
            end else if (en) begin
                dv_side_reg[k] <= dv_side_reg[k-1];
            end
        end
    end

    // ---------------- divider stages
    logic [DVD_W-1:0] quo_a [3];
    logic [DVD_W-1:0] quo_b [3];
    logic [DVS_W-1:0] rmd_a [3];
    logic [DVS_W-1:0] rmd_b [3];

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_div
            vfa_udiv u_div_a (
                .aclk(aclk), .en(en), .dividend(dvd_a_reg[g]), .divisor(dvs_a_reg),
                .quot(quo_a[g]), .rmd(rmd_a[g])
            );
            vfa_udiv u_div_b (
                .aclk(aclk), .en(en), .dividend(dvd_b_reg[g]), .divisor(dvs_b_reg),
                .quot(quo_b[g]), .rmd(rmd_b[g])
            );
        end
    endgenerate

    // ---------------- stage U: signed unit components and remainders
    dv_side_t               dv_o;
    logic signed [Q_W-1:0]  ua_reg [3];
    logic signed [Q_W-1:0]  ub_reg [3];
    vr_side_t               u_side_reg;
    logic [Q_W-1:0]         rem_r  [3];
    logic [Q_W-1:0]         ua_r   [3];

    assign dv_o = dv_side_reg[DIV_STG];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            // remainder magnitude stays below 2^31, sign follows a
            rem_r[i] = dv_o.a_neg[i] ? (~rmd_a[i] + Q_W'(1)) : rmd_a[i];
            ua_r[i]  = sign_sat(quo_a[i], dv_o.a_neg[i]);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            u_side_reg.vld <= 1'b0;
        end else if (en) begin
            u_side_reg.vld <= dv_o.vld;
        end
        if (en) begin
            u_side_reg.cmd    <= dv_o.cmd;
            u_side_reg.s_zero <= dv_o.s_zero;
            u_side_reg.a_zero <= dv_o.a_zero;
            u_side_reg.b_zero <= dv_o.b_zero;
            u_side_reg.norm_s <= dv_o.norm_s;
            for (int i = 0; i < 3; i++) begin
                ua_reg[i] <= ua_r[i];
                ub_reg[i] <= sign_sat(quo_b[i], dv_o.b_neg[i]);
                case (dv_o.cmd)
                    CMD_REM:  u_side_reg.vec_r[i] <= rem_r[i];
                    CMD_UNIT: u_side_reg.vec_r[i] <= ua_r[i];
                    default:  u_side_reg.vec_r[i] <= dv_o.pre_r[i];
                endcase
            end
        end
    end

    // ---------------- stage P: unit-vector products, index 3*i+j
    logic signed [2*Q_W-1:0] p_reg [9];
    vr_side_t                p_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p_side_reg.vld <= 1'b0;
        end else if (en) begin
            p_side_reg.vld <= u_side_reg.vld;
        end
        if (en) begin
            p_side_reg.cmd    <= u_side_reg.cmd;
            p_side_reg.s_zero <= u_side_reg.s_zero;
            p_side_reg.a_zero <= u_side_reg.a_zero;
            p_side_reg.b_zero <= u_side_reg.b_zero;
            p_side_reg.norm_s <= u_side_reg.norm_s;
            p_side_reg.vec_r  <= u_side_reg.vec_r;
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    p_reg[3*i+j] <= (2*Q_W)'(ua_reg[i]) * (2*Q_W)'(ub_reg[j]);
                end
            end
        end
    end

    // ---------------- stage S: sums with rounding bias
    logic signed [65:0] dot_reg;
    logic signed [65:0] cx_reg;
    logic signed [65:0] cy_reg;
    logic signed [65:0] cz_reg;
    vr_side_t           s_side_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s_side_reg.vld <= 1'b0;
        end else if (en) begin
            s_side_reg.vld <= p_side_reg.vld;
        end
        if (en) begin
            s_side_reg.cmd    <= p_side_reg.cmd;
            s_side_reg.s_zero <= p_side_reg.s_zero;
            s_side_reg.a_zero <= p_side_reg.a_zero;
            s_side_reg.b_zero <= p_side_reg.b_zero;
            s_side_reg.norm_s <= p_side_reg.norm_s;
            s_side_reg.vec_r  <= p_side_reg.vec_r;
            dot_reg <= 66'(p_reg[0]) + 66'(p_reg[4]) + 66'(p_reg[8]) + 66'sd32768;
            cx_reg  <= 66'(p_reg[5]) - 66'(p_reg[7]) + 66'sd32768;
            cy_reg  <= 66'(p_reg[6]) - 66'(p_reg[2]) + 66'sd32768;
            cz_reg  <= 66'(p_reg[1]) - 66'(p_reg[3]) + 66'sd32768;
        end
    end

    // ---------------- stage O: command select, output register
    out_t out_next;
    out_t out_reg;
    logic out_vld_reg;

    always_comb begin
        out_next = '0;
        case (s_side_reg.cmd)
            CMD_NEG, CMD_ADD, CMD_SUB, CMD_SCALE: begin
                out_next.r_x = s_side_reg.vec_r[0];
                out_next.r_y = s_side_reg.vec_r[1];
                out_next.r_z = s_side_reg.vec_r[2];
            end
            CMD_REM, CMD_UNIT: begin
                if ((s_side_reg.cmd == CMD_REM && s_side_reg.s_zero) ||
                    (s_side_reg.cmd == CMD_UNIT && s_side_reg.a_zero)) begin
                    out_next.error_flag = 1'b1;
                end else begin
                    out_next.r_x = s_side_reg.vec_r[0];
                    out_next.r_y = s_side_reg.vec_r[1];
                    out_next.r_z = s_side_reg.vec_r[2];
                end
            end
            CMD_NORM: begin
                out_next.r_scalar = s_side_reg.norm_s;
            end
            CMD_DOT: begin
                if (s_side_reg.a_zero || s_side_reg.b_zero) begin
                    out_next.error_flag = 1'b1;
                end else begin
                    out_next.r_scalar = sat32(dot_reg >>> FRAC_W);
                end
            end
            CMD_CROSS: begin
                if (s_side_reg.a_zero || s_side_reg.b_zero) begin
                    out_next.error_flag = 1'b1;
                end else begin
                    out_next.r_x = sat32(cx_reg >>> FRAC_W);
                    out_next.r_y = sat32(cy_reg >>> FRAC_W);
                    out_next.r_z = sat32(cz_reg >>> FRAC_W);
                end
            end
            default: begin
                out_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (en) begin
            out_vld_reg <= s_side_reg.vld;
        end
        if (en) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

endmodule

// ----- rtl/core/vfa_isqrt.sv -----
// ----------------------------------------------------------------------------
// vfa_isqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module vfa_isqrt (
    input  logic                         aclk,
    input  logic                         en,
    input  logic [vfa_pkg::SQ_W-1:0]     rad,
    output logic [vfa_pkg::ROOT_W-1:0]   root
);
    import vfa_pkg::*;

    logic [SQ_W-1:0]   rad_reg  [ROOT_W];
    logic [ROOT_W+1:0] rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++) begin : g_stg
            logic [SQ_W-1:0]   rad_in;
            logic [ROOT_W+1:0] rem_in;
            logic [ROOT_W-1:0] root_in;
            logic [ROOT_W+3:0] rem_sh;
            logic [ROOT_W+3:0] trial;
            logic [ROOT_W+3:0] diff;
            logic              ge;

            if (k == 0) begin : g_first
                assign rad_in  = rad;
                assign rem_in  = '0;
                assign root_in = '0;
            end else begin : g_next
                assign rad_in  = rad_reg[k-1];
                assign rem_in  = rem_reg[k-1];
                assign root_in = root_reg[k-1];
            end

            // bring down the next two radicand bits, try 4q+1
            assign rem_sh = {rem_in, rad_in[SQ_W-1 -: 2]};
            assign trial  = {2'b00, root_in, 2'b01};
            assign diff   = rem_sh - trial;
            assign ge     = (rem_sh >= trial);

            always_ff @(posedge aclk) begin
                if (en) begin
                    rad_reg[k]  <= rad_in << 2;
                    rem_reg[k]  <= ge ? diff[ROOT_W+1:0] : rem_sh[ROOT_W+1:0];
                    root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                end
            end
        end
    endgenerate

    assign root = root_reg[ROOT_W-1];

endmodule

// ----- rtl/core/vfa_udiv.sv -----
// ----------------------------------------------------------------------------
// vfa_udiv
// Pipelined unsigned restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module vfa_udiv (
    input  logic                        aclk,
    input  logic                        en,
    input  logic [vfa_pkg::DVD_W-1:0]   dividend,
    input  logic [vfa_pkg::DVS_W-1:0]   divisor,
    output logic [vfa_pkg::DVD_W-1:0]   quot,
    output logic [vfa_pkg::DVS_W-1:0]   rmd
);
    import vfa_pkg::*;

    logic [DVD_W-1:0] dq_reg  [DVD_W];
    logic [DVS_W-1:0] rem_reg [DVD_W];
    logic [DVS_W-1:0] dvs_reg [DVD_W];

    genvar k;
    generate
        for (k = 0; k < DVD_W; k++) begin : g_stg
            logic [DVD_W-1:0] dq_in;
            logic [DVS_W-1:0] rem_in;
            logic [DVS_W-1:0] dvs_in;
            logic [DVS_W:0]   sh;
            logic [DVS_W:0]   diff;
            logic             ge;

            if (k == 0) begin : g_first
                assign dq_in  = dividend;
                assign rem_in = '0;
                assign dvs_in = divisor;
            end else begin : g_next
                assign dq_in  = dq_reg[k-1];
                assign rem_in = rem_reg[k-1];
                assign dvs_in = dvs_reg[k-1];
            end

            // dividend bits shift out at the top, quotient bits shift in below
            assign sh   = {rem_in, dq_in[DVD_W-1]};
            assign diff = sh - {1'b0, dvs_in};
            assign ge   = (sh >= {1'b0, dvs_in});

            always_ff @(posedge aclk) begin
                if (en) begin
                    dq_reg[k]  <= {dq_in[DVD_W-2:0], ge};
                    rem_reg[k] <= ge ? diff[DVS_W-1:0] : sh[DVS_W-1:0];
                    dvs_reg[k] <= dvs_in;
                end
            end
        end
    endgenerate

    assign quot = dq_reg[DVD_W-1];
    assign rmd  = rem_reg[DVD_W-1];

endmodule
